### sv/whwf_pkg.sv
// Shared types and constants for the weighted window hole fill unit.
// No dependencies; every other file refers to it by scoped names.
package whwf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int TW         = $clog2(3 * MAX_WIDTH + 4);
    localparam int FIFO_DEPTH = 8;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int PIX_W      = 25;

    localparam logic [1:0] ST_MAPPED   = 2'd0;
    localparam logic [1:0] ST_FILLED   = 2'd1;
    localparam logic [1:0] ST_UNFILLED = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [10:0] width;
        logic [11:0] height;
        logic        restart;
    } whwf_cfg_t;

    // one neighbourhood, summed, waiting for the divider
    typedef struct packed {
        logic [13:0] sum_r;
        logic [13:0] sum_g;
        logic [13:0] sum_b;
        logic [6:0]  cnt;
        logic [24:0] centre;
        logic        frame_end;
    } whwf_item_t;

    // weight mask, symmetric, zero at the centre
    function automatic logic [1:0] weight(input int a, input int b);
        logic [1:0] w;
        int da;
        int db;
        da = (a < 3) ? 3 - a : a - 3;
        db = (b < 3) ? 3 - b : b - 3;
        w = 2'd1;
        if (da == 0 && db == 0)
            w = 2'd0;
        else if ((da == 0 && db == 1) || (da == 1 && db == 0))
            w = 2'd3;
        else if ((da == 0 && db == 2) || (da == 2 && db == 0) || (da == 1 && db == 1))
            w = 2'd2;
        else if ((da == 0 && db == 3) || (da == 3 && db == 0))
            w = 2'd1;
        return w;
    endfunction

endpackage

### sv/weighted_window_hole_fill_unit.sv
// Top level of the weighted window hole fill unit: register port, front, queue, back.
// Depends on whwf_pkg, whwf_front, whwf_fifo and whwf_back.
//
//  channel | direction | word contents
//  s_*     | in        | tdata {blue,green,red}, tuser {mapped,opcode}
//  m_*     | out       | tdata {blue,green,red}, tuser fill_status, tlast frame_end
//  apb     | in/out    | 0x0 image_width, 0x4 image_height
//
// One pixel per clock sustained while m_tready stays high. A pixel leaves 3*width+3 words
// after it entered, then passes the window, sum tree and the eight-stage divider.
// Reset clears counters and pipeline valids; line stores are not cleared.
// Stalls fill the eight-word queue; s_tready drops once it and the front hold eight.
// A register write restarts the frame counters.
module weighted_window_hole_fill_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic [1:0]  s_tuser,   // opcode [0], mapped [1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic [1:0]  m_tuser,   // fill_status [1:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic        wr_en;

    whwf_pkg::whwf_cfg_t            cfg;
    whwf_pkg::whwf_item_t           push_item, head;
    logic                           push, pop, empty;
    logic [whwf_pkg::FAW:0]         fifo_count;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                whwf_pkg::REG_WIDTH:  width_reg  <= pwdata[10:0];
                whwf_pkg::REG_HEIGHT: height_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            whwf_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            whwf_pkg::REG_HEIGHT: prdata = {20'd0, height_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;
    assign cfg.restart = wr_en;

    whwf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_count (fifo_count),
        .push       (push),
        .push_item  (push_item)
    );

    whwf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .empty     (empty),
        .head      (head),
        .count     (fifo_count)
    );

    whwf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/whwf_front.sv
// Front end: raster counters, six line stores, 7x7 window and weighted sums.
// Depends on whwf_pkg.
module whwf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  whwf_pkg::whwf_cfg_t     cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // red, green, blue
    input  logic [1:0]              s_tuser,   // opcode, mapped
    input  logic [whwf_pkg::FAW:0]  fifo_count,
    output logic                    push,
    output whwf_pkg::whwf_item_t    push_item
);

    localparam int XW = whwf_pkg::XW;
    localparam int WW = whwf_pkg::WW;
    localparam int TW = whwf_pkg::TW;
    localparam int LSW = 6 * whwf_pkg::PIX_W;

    logic [WW-1:0] eff_w;
    logic [11:0]   eff_h;
    logic [TW-1:0] thresh;

    logic [XW-1:0] in_col_reg, in_col_next;
    logic [TW-1:0] fill_reg, fill_next;
    logic [XW-1:0] out_col_reg, out_col_next;
    logic [11:0]   out_row_reg, out_row_next;

    logic fire, drop, acc, emit, col_last, out_col_last, fend;
    logic [24:0] word;
    logic [6:0]  row_ok, col_ok;

    // stage 0: line store read in flight
    logic          v0_reg, emit0_reg, fend0_reg, byp_reg;
    logic [24:0]   word0_reg;
    logic [XW-1:0] x0_reg;
    logic [6:0]    rok0_reg, cok0_reg;
    logic [LSW-1:0] rd_reg, hold_reg, col_old, ls_wdata;
    logic [LSW-1:0] ls_mem [whwf_pkg::MAX_WIDTH];

    logic [24:0] win_reg [7][7];   // [column age][row age]

    // stage 1: window settled for this item
    logic       v1_reg, fend1_reg;
    logic [6:0] rok1_reg, cok1_reg;

    // stage 2: row sums
    logic        v2_reg, fend2_reg;
    logic [11:0] rs_r_reg [7];
    logic [11:0] rs_g_reg [7];
    logic [11:0] rs_b_reg [7];
    logic [3:0]  rc_reg [7];
    logic [24:0] centre2_reg;

    logic [11:0] rs_r [7];
    logic [11:0] rs_g [7];
    logic [11:0] rs_b [7];
    logic [3:0]  rc [7];

    always_comb
    begin
        if (cfg.width == 11'd0)
            eff_w = WW'(1);
        else if (WW'(cfg.width) > WW'(whwf_pkg::MAX_WIDTH) || cfg.width > 11'(whwf_pkg::MAX_WIDTH))
            eff_w = WW'(whwf_pkg::MAX_WIDTH);
        else
            eff_w = WW'(cfg.width);
        eff_h = (cfg.height == 12'd0) ? 12'd1 : cfg.height;
        thresh = TW'({eff_w, 1'b0}) + TW'(eff_w) + TW'(3);
    end

    assign s_tready = ((TW+4)'(fifo_count) + (TW+4)'(v0_reg) + (TW+4)'(v1_reg)
                       + (TW+4)'(v2_reg)) < (TW+4)'(whwf_pkg::FIFO_DEPTH);
    assign fire = s_tvalid && s_tready;
    assign drop = (s_tuser[0] == whwf_pkg::OP_FLUSH) && (fill_reg == '0);
    assign acc  = fire && !drop;
    assign emit = (fill_reg == thresh);
    assign word = (s_tuser[0] == whwf_pkg::OP_FLUSH) ? 25'd0 : {s_tuser[1], s_tdata};

    assign col_last     = (WW'(in_col_reg) + WW'(1)) >= eff_w;
    assign out_col_last = (WW'(out_col_reg) + WW'(1)) >= eff_w;
    assign fend         = emit && out_col_last && ((13'(out_row_reg) + 13'd1) >= 13'(eff_h));

    always_comb
    begin
        for (int a = 0; a < 7; a++)
        begin
            if (a < 3)
                row_ok[a] = out_row_reg >= 12'(3 - a);
            else
                row_ok[a] = (13'(out_row_reg) + 13'(a - 3)) < 13'(eff_h);
            if (a < 3)
                col_ok[a] = out_col_reg >= XW'(3 - a);
            else
                col_ok[a] = ((WW+1)'(out_col_reg) + (WW+1)'(a - 3)) < (WW+1)'(eff_w);
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        fill_next    = fill_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg.restart || (acc && fend))
        begin
            in_col_next  = '0;
            fill_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (acc)
        begin
            in_col_next = col_last ? '0 : in_col_reg + XW'(1);
            if (!emit)
                fill_next = fill_reg + TW'(1);
            if (emit)
            begin
                out_col_next = out_col_last ? '0 : out_col_reg + XW'(1);
                if (out_col_last)
                    out_row_next = out_row_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            fill_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            fill_reg    <= fill_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            v0_reg      <= acc;
            v1_reg      <= v0_reg && emit0_reg;
            v2_reg      <= v1_reg;
            // read of the column just being written: take the write data
            byp_reg     <= acc && v0_reg && (in_col_reg == x0_reg);
        end
    end

    assign col_old  = byp_reg ? hold_reg : rd_reg;
    assign ls_wdata = {col_old[LSW-26:0], word0_reg};

    always_ff @(posedge clk)
    begin
        if (v0_reg)
            ls_mem[x0_reg] <= ls_wdata;
        if (acc)
            rd_reg <= ls_mem[in_col_reg];
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= ls_wdata;
        if (acc)
        begin
            word0_reg <= word;
            x0_reg    <= in_col_reg;
            emit0_reg <= emit;
            fend0_reg <= fend;
            rok0_reg  <= row_ok;
            cok0_reg  <= col_ok;
        end
        if (v0_reg)
        begin
            for (int c = 6; c > 0; c--)
                for (int r = 0; r < 7; r++)
                    win_reg[c][r] <= win_reg[c-1][r];
            win_reg[0][0] <= word0_reg;
            for (int r = 1; r < 7; r++)
                win_reg[0][r] <= col_old[(r-1)*25 +: 25];
            fend1_reg <= fend0_reg;
            rok1_reg  <= rok0_reg;
            cok1_reg  <= cok0_reg;
        end
    end

    // neighbour row a (dr = a-3), column b (dc = b-3) sits at column age 6-b, row age 6-a
    always_comb
    begin
        for (int a = 0; a < 7; a++)
        begin
            rs_r[a] = '0;
            rs_g[a] = '0;
            rs_b[a] = '0;
            rc[a]   = '0;
            for (int b = 0; b < 7; b++)
            begin
                if (rok1_reg[a] && cok1_reg[b] && win_reg[6-b][6-a][24])
                begin
                    rs_r[a] = rs_r[a] + 12'(whwf_pkg::weight(a, b)) * 12'(win_reg[6-b][6-a][7:0]);
                    rs_g[a] = rs_g[a] + 12'(whwf_pkg::weight(a, b)) * 12'(win_reg[6-b][6-a][15:8]);
                    rs_b[a] = rs_b[a] + 12'(whwf_pkg::weight(a, b)) * 12'(win_reg[6-b][6-a][23:16]);
                    rc[a]   = rc[a] + 4'(whwf_pkg::weight(a, b));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int a = 0; a < 7; a++)
            begin
                rs_r_reg[a] <= rs_r[a];
                rs_g_reg[a] <= rs_g[a];
                rs_b_reg[a] <= rs_b[a];
                rc_reg[a]   <= rc[a];
            end
            centre2_reg <= win_reg[3][3];
            fend2_reg   <= fend1_reg;
        end
    end

    always_comb
    begin
        push_item.sum_r = '0;
        push_item.sum_g = '0;
        push_item.sum_b = '0;
        push_item.cnt   = '0;
        for (int a = 0; a < 7; a++)
        begin
            push_item.sum_r = push_item.sum_r + 14'(rs_r_reg[a]);
            push_item.sum_g = push_item.sum_g + 14'(rs_g_reg[a]);
            push_item.sum_b = push_item.sum_b + 14'(rs_b_reg[a]);
            push_item.cnt   = push_item.cnt + 7'(rc_reg[a]);
        end
        push_item.centre    = centre2_reg;
        push_item.frame_end = fend2_reg;
    end

    assign push = v2_reg;

endmodule

### sv/whwf_fifo.sv
// Short queue between the front and back ends.
// Depends on whwf_pkg.
module whwf_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  whwf_pkg::whwf_item_t    push_item,
    input  logic                    pop,
    output logic                    empty,
    output whwf_pkg::whwf_item_t    head,
    output logic [whwf_pkg::FAW:0]  count
);

    localparam int FAW = whwf_pkg::FAW;

    whwf_pkg::whwf_item_t mem_reg [whwf_pkg::FIFO_DEPTH];
    logic [FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FAW:0]   count_reg;
    logic           do_pop;

    assign empty  = (count_reg == '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign count  = count_reg;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            count_reg <= count_reg + (FAW+1)'(push) - (FAW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### sv/whwf_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, and result select.
// Depends on whwf_pkg.
module whwf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  whwf_pkg::whwf_item_t    head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // red, green, blue
    output logic [1:0]              m_tuser,   // fill_status
    output logic                    m_tlast
);

    logic        v_reg [8];
    logic [13:0] rem_reg [8][3];
    logic [7:0]  q_reg [8][3];
    logic [6:0]  d_reg [8];
    logic [24:0] centre_reg [8];
    logic        fend_reg [8];
    logic        en;
    logic [13:0] src [3];

    function automatic logic [13:0] sub_step(input logic [13:0] rem, input logic [6:0] d,
                                             input int sh);
        logic [13:0] ds;
        ds = 14'(d) << sh;
        return (rem >= ds) ? rem - ds : rem;
    endfunction

    function automatic logic q_bit(input logic [13:0] rem, input logic [6:0] d, input int sh);
        logic [13:0] ds;
        ds = 14'(d) << sh;
        return rem >= ds;
    endfunction

    assign en  = !v_reg[7] || m_tready;
    assign pop = en && !empty;

    assign src[0] = head.sum_r;
    assign src[1] = head.sum_g;
    assign src[2] = head.sum_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !empty;
            for (int k = 1; k < 8; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[0][c] <= sub_step(src[c], head.cnt, 7);
                q_reg[0][c]   <= {q_bit(src[c], head.cnt, 7), 7'd0};
            end
            d_reg[0]      <= head.cnt;
            centre_reg[0] <= head.centre;
            fend_reg[0]   <= head.frame_end;
            for (int k = 1; k < 8; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[k][c] <= sub_step(rem_reg[k-1][c], d_reg[k-1], 7 - k);
                    q_reg[k][c]   <= q_reg[k-1][c]
                                     | (8'(q_bit(rem_reg[k-1][c], d_reg[k-1], 7 - k)) << (7 - k));
                end
                d_reg[k]      <= d_reg[k-1];
                centre_reg[k] <= centre_reg[k-1];
                fend_reg[k]   <= fend_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (centre_reg[7][24])
        begin
            m_tdata = centre_reg[7][23:0];
            m_tuser = whwf_pkg::ST_MAPPED;
        end
        else if (d_reg[7] == 7'd0)
        begin
            m_tdata = centre_reg[7][23:0];
            m_tuser = whwf_pkg::ST_UNFILLED;
        end
        else
        begin
            m_tdata = {q_reg[7][2], q_reg[7][1], q_reg[7][0]};
            m_tuser = whwf_pkg::ST_FILLED;
        end
    end

    assign m_tvalid = v_reg[7];
    assign m_tlast  = fend_reg[7];

endmodule
